### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/raec_pkg.sv
// types, widths, constants and rounding helpers of the axis error compensation
package raec_pkg;

  localparam int ANG_W   = 23;   // angle as loaded, 1e-4 degree
  localparam int ANGQ_W  = 25;   // query angle after the C wrap
  localparam int POS_W   = 28;
  localparam int ERR_W   = 21;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 10;
  localparam int SPAN_W  = 24;   // difference of two node angles
  localparam int NUM_W   = 27;   // ratio numerator
  localparam int QF      = 16;   // fraction bits of the shape functions
  localparam int DVD_W   = NUM_W + QF + 1;
  localparam int RAT_W   = 22;   // ratio, saturated to +-2^20
  localparam int US_W    = 26;
  localparam int NJ_W    = 34;
  localparam int PROD_W  = NJ_W + US_W;
  localparam int SQ_W    = 48;
  localparam int DIST_W  = SQ_W + 1;

  localparam int C_WRAP    = 3600000;
  localparam int Q_ONE     = 65536;
  localparam int RATIO_MAX = 1048576;
  localparam int ERR_MAX   = 1000000;
  localparam int OUT_MAX   = 101000000;

  typedef struct packed {
    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W-1:0] c;
    logic signed [ERR_W-1:0] ex;
    logic signed [ERR_W-1:0] ey;
    logic signed [ERR_W-1:0] ez;
  } node_t;

  // the four quadrant candidates, index is the quadrant
  typedef node_t [3:0] cand_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] ex;
    logic signed [ERR_W-1:0] ey;
    logic signed [ERR_W-1:0] ez;
    logic                    degen;
  } res_t;

  // divide by 2^sh, round to nearest with ties away from zero
  function automatic logic signed [PROD_W-1:0] rnd_pow2(input logic signed [PROD_W-1:0] v,
                                                        input int unsigned sh);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    q   = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
    return v[PROD_W-1] ? -$signed(q) : $signed(q);
  endfunction

  // symmetric saturation
  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

### hw/rtl/raec_div.sv
// shared restoring divider: rounded num*2^16/den, saturated to +-2^20
module raec_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [raec_pkg::NUM_W-1:0]  num,
  input  logic signed [raec_pkg::SPAN_W-1:0] den,
  output logic                              done,
  output logic signed [raec_pkg::RAT_W-1:0]  quo
);
  import raec_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W-1:0] dmag_r;
  logic              neg_r;

  logic [NUM_W-1:0]  nmag;
  logic [SPAN_W-1:0] dmag;
  logic [SPAN_W:0]   rem_sh;
  logic              ge;
  logic [DVD_W-1:0]  qmag;
  logic [RAT_W-1:0]  qsat;

  // operand magnitudes, rounding offset folded into the dividend
  assign nmag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dmag   = den[SPAN_W-1] ? SPAN_W'(-den) : SPAN_W'(den);
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag_r};

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {1'b0, nmag, {QF{1'b0}}} + DVD_W'(dmag >> 1);
      rem_r  <= '0;
      dmag_r <= dmag;
      neg_r  <= num[NUM_W-1] ^ den[SPAN_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? SPAN_W'(rem_sh - {1'b0, dmag_r}) : SPAN_W'(rem_sh);
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  // saturate and restore the sign
  assign qmag = dvd_r;
  assign qsat = (qmag > DVD_W'(RATIO_MAX)) ? RAT_W'(RATIO_MAX) : RAT_W'(qmag);
  assign quo  = neg_r ? -$signed(qsat) : $signed(qsat);
  assign done = done_r;

endmodule

### hw/rtl/raec_scan.sv
// node table and nearest-node search in four quadrants, one node a cycle
module raec_scan #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int NW    = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  raec_pkg::node_t                   wr_data,
  input  logic                              start,
  input  logic signed [raec_pkg::ANGQ_W-1:0] q_a,
  input  logic signed [raec_pkg::ANGQ_W-1:0] q_c,
  input  logic [NW-1:0]                     scan_len,
  output logic                              done,
  output raec_pkg::cand_t                   cand
);
  import raec_pkg::*;

  node_t mem [DEPTH];
  node_t rd_r;

  logic           busy_r;
  logic           done_r;
  logic [NW:0]    cnt_r;
  logic [NW:0]    total;
  logic [NW:0]    off;
  logic           issue;

  logic           p1_v_r;
  logic           p1_seed_r;
  logic [1:0]     p1_sq_r;
  logic           p2_v_r;
  logic           p2_seed_r;
  logic [1:0]     p2_q_r;
  node_t          p2_node_r;
  logic [SQ_W-1:0] sqa_r;
  logic [SQ_W-1:0] sqc_r;

  cand_t           cand_r;
  logic [DIST_W-1:0] cdist_r [4];

  logic signed [ANGQ_W-1:0]   da;
  logic signed [ANGQ_W-1:0]   dc;
  logic signed [2*ANGQ_W-1:0] da2;
  logic signed [2*ANGQ_W-1:0] dc2;
  logic [1:0]                 quad;
  logic [DIST_W-1:0]          sq_sum;
  logic                       take;

  // seeds from nodes 0 to 3 first, then the nodes in use
  assign total = {1'b0, scan_len} + (NW+1)'(4);
  assign issue = busy_r && (cnt_r != total);
  assign off   = (cnt_r < (NW+1)'(4)) ? cnt_r : cnt_r - (NW+1)'(4);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[off[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + (NW+1)'(1);
      end else if (busy_r && !p1_v_r && !p2_v_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // distance terms and quadrant of the node just read
  assign da   = ANGQ_W'(rd_r.a) - q_a;
  assign dc   = ANGQ_W'(rd_r.c) - q_c;
  assign da2  = da * da;
  assign dc2  = dc * dc;
  always_comb begin
    if (p1_seed_r) begin
      quad = p1_sq_r;
    end else if (ANGQ_W'(rd_r.a) <= q_a) begin
      quad = (ANGQ_W'(rd_r.c) <= q_c) ? 2'd0 : 2'd1;
    end else begin
      quad = (ANGQ_W'(rd_r.c) >= q_c) ? 2'd2 : 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_seed_r <= cnt_r < (NW+1)'(4);
    p1_sq_r   <= cnt_r[1:0];
    p2_seed_r <= p1_seed_r;
    p2_q_r    <= quad;
    p2_node_r <= rd_r;
    sqa_r     <= SQ_W'(da2);
    sqc_r     <= SQ_W'(dc2);
  end

  // a seed, or a strictly nearer node, replaces its quadrant's candidate
  assign sq_sum = DIST_W'(sqa_r) + DIST_W'(sqc_r);
  assign take   = p2_v_r && (p2_seed_r || (sq_sum < cdist_r[p2_q_r]));

  always_ff @(posedge clk) begin
    if (take) begin
      cand_r[p2_q_r]  <= p2_node_r;
      cdist_r[p2_q_r] <= sq_sum;
    end
  end

  assign cand = cand_r;
  assign done = done_r;

endmodule

### hw/rtl/raec_interp.sv
// bilinear shape functions and weighted error sum on one shared multiplier
module raec_interp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [raec_pkg::ANGQ_W-1:0] q_a,
  input  logic signed [raec_pkg::ANGQ_W-1:0] q_c,
  input  raec_pkg::cand_t                   cand,
  output logic                              done,
  output raec_pkg::res_t                    res
);
  import raec_pkg::*;

  localparam logic [2:0] IS_IDLE = 3'd0;
  localparam logic [2:0] IS_SPAN = 3'd1;
  localparam logic [2:0] IS_DIV  = 3'd2;
  localparam logic [2:0] IS_DIVW = 3'd3;
  localparam logic [2:0] IS_MUL  = 3'd4;
  localparam logic [2:0] IS_FIN  = 3'd5;

  localparam logic [3:0] DIV_S    = 4'd0;
  localparam logic [3:0] DIV_T    = 4'd1;
  localparam logic [3:0] DIV_TJ0  = 4'd6;
  localparam logic [3:0] DIV_LAST = 4'd9;

  localparam logic [3:0] M_S    = 4'd0;
  localparam logic [3:0] M_T    = 4'd1;
  localparam logic [3:0] M_UT   = 4'd2;
  localparam logic [3:0] M_N    = 4'd3;
  localparam logic [3:0] M_NJ   = 4'd4;
  localparam logic [3:0] M_EX   = 4'd5;
  localparam logic [3:0] M_EY   = 4'd6;
  localparam logic [3:0] M_EZ   = 4'd7;
  localparam logic [3:0] M_LAST = 4'd8;

  logic [2:0] state_r;
  logic [3:0] didx_r;
  logic [3:0] step_r;
  logic [1:0] k_r;
  logic       done_r;

  logic signed [SPAN_W-1:0] da_r;
  logic signed [SPAN_W-1:0] dc_r;
  logic signed [RAT_W-1:0]  s_r;
  logic signed [RAT_W-1:0]  t_r;
  logic signed [RAT_W-1:0]  sj_r [4];
  logic signed [RAT_W-1:0]  tj_r [4];
  logic signed [US_W-1:0]   us_r;
  logic signed [US_W-1:0]   ut_r;
  logic signed [NJ_W-1:0]   nj_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r [3];
  res_t                     res_r;

  logic signed [SPAN_W-1:0] span_a;
  logic signed [SPAN_W-1:0] span_c;
  logic [1:0]               kd;
  logic signed [NUM_W-1:0]  num;
  logic signed [SPAN_W-1:0] den;
  logic                     div_start;
  logic                     div_done;
  logic signed [RAT_W-1:0]  div_quo;
  logic signed [NJ_W-1:0]   mul_a;
  logic signed [US_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] rnd16;

  assign span_a = SPAN_W'(cand[2].a) - SPAN_W'(cand[0].a);
  assign span_c = SPAN_W'(cand[1].c) - SPAN_W'(cand[0].c);

  // ratio operands: query s, query t, then sj of each candidate, then tj of each candidate
  assign kd = didx_r[1:0] - 2'd2;
  always_comb begin
    if (didx_r == DIV_S) begin
      num = (NUM_W'(q_a) <<< 1) - NUM_W'(cand[0].a) - NUM_W'(cand[2].a);
      den = da_r;
    end else if (didx_r == DIV_T) begin
      num = (NUM_W'(q_c) <<< 1) - NUM_W'(cand[0].c) - NUM_W'(cand[1].c);
      den = dc_r;
    end else if (didx_r < DIV_TJ0) begin
      num = (NUM_W'(cand[kd].a) <<< 1) - NUM_W'(cand[0].a) - NUM_W'(cand[2].a);
      den = da_r;
    end else begin
      num = (NUM_W'(cand[kd].c) <<< 1) - NUM_W'(cand[0].c) - NUM_W'(cand[1].c);
      den = dc_r;
    end
  end

  assign div_start = (state_r == IS_DIV);

  raec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      M_S: begin
        mul_a = NJ_W'(s_r);
        mul_b = US_W'(sj_r[k_r]);
      end
      M_T: begin
        mul_a = NJ_W'(t_r);
        mul_b = US_W'(tj_r[k_r]);
      end
      M_N: begin
        mul_a = NJ_W'(us_r);
        mul_b = ut_r;
      end
      M_EX: begin
        mul_a = nj_r;
        mul_b = US_W'(cand[k_r].ex);
      end
      M_EY: begin
        mul_a = nj_r;
        mul_b = US_W'(cand[k_r].ey);
      end
      M_EZ: begin
        mul_a = nj_r;
        mul_b = US_W'(cand[k_r].ez);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign rnd16 = PROD_W'(Q_ONE) + rnd_pow2(prod_r, QF);

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IS_IDLE;
      didx_r  <= '0;
      step_r  <= '0;
      k_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        IS_IDLE: begin
          if (start) begin
            state_r <= IS_SPAN;
          end
        end
        IS_SPAN: begin
          didx_r <= DIV_S;
          if (span_a == '0 || span_c == '0) begin
            state_r <= IS_IDLE;
            done_r  <= 1'b1;
          end else begin
            state_r <= IS_DIV;
          end
        end
        IS_DIV: begin
          state_r <= IS_DIVW;
        end
        IS_DIVW: begin
          if (div_done) begin
            if (didx_r == DIV_LAST) begin
              state_r <= IS_MUL;
              step_r  <= M_S;
              k_r     <= '0;
            end else begin
              didx_r  <= didx_r + 4'd1;
              state_r <= IS_DIV;
            end
          end
        end
        IS_MUL: begin
          if (step_r == M_LAST) begin
            step_r <= M_S;
            k_r    <= k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_r <= IS_FIN;
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        IS_FIN: begin
          state_r <= IS_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          state_r <= IS_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      IS_SPAN: begin
        da_r     <= span_a;
        dc_r     <= span_c;
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
        if (span_a == '0 || span_c == '0) begin
          res_r <= '{ex: '0, ey: '0, ez: '0, degen: 1'b1};
        end
      end
      IS_DIVW: begin
        if (div_done) begin
          if (didx_r == DIV_S) begin
            s_r <= div_quo;
          end else if (didx_r == DIV_T) begin
            t_r <= div_quo;
          end else if (didx_r < DIV_TJ0) begin
            sj_r[kd] <= div_quo;
          end else begin
            tj_r[kd] <= div_quo;
          end
        end
      end
      IS_MUL: begin
        prod_r <= mul_p;
        case (step_r)
          M_T:     us_r <= US_W'(rnd16);
          M_UT:    ut_r <= US_W'(rnd16);
          M_NJ:    nj_r <= NJ_W'(rnd_pow2(prod_r, QF + 2));
          M_EY:    acc_r[0] <= acc_r[0] + prod_r;
          M_EZ:    acc_r[1] <= acc_r[1] + prod_r;
          M_LAST:  acc_r[2] <= acc_r[2] + prod_r;
          default: ;
        endcase
      end
      IS_FIN: begin
        res_r.ex    <= ERR_W'(clamp64(64'(rnd_pow2(acc_r[0], QF)), 64'(ERR_MAX)));
        res_r.ey    <= ERR_W'(clamp64(64'(rnd_pow2(acc_r[1], QF)), 64'(ERR_MAX)));
        res_r.ez    <= ERR_W'(clamp64(64'(rnd_pow2(acc_r[2], QF)), 64'(ERR_MAX)));
        res_r.degen <= 1'b0;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### hw/rtl/rotary_axis_error_compensation.sv
// top level of the rotary-axis error compensation block
//
// Input channel in_*: one word is either a node load (in_tuser low) or a
// compensation query (in_tuser high). A load writes one node of the table in
// the cycle it is accepted and gives no result. A query scans nodes 0 to n-1,
// n being entries_in_use capped at TABLE_DEPTH, keeps the nearest node in each
// of four quadrants around (A, C), and interpolates the XYZ error.
// Result channel out_*: one word per query, corrected XYZ and error in
// out_tdata, degenerate-span flag in out_tuser.
// Configuration: cfg_wr_en with cfg_wr_data sets entries_in_use; write only
// while the block is idle.
// Sequencing: a load leaves the block idle with in_tready high. A query runs
// the table scan (one node read per cycle from the table memory), then, unless
// the span is degenerate, ten ratios through the shared 44-step divider and the
// weighted error sum on the shared multiplier. One item is worked at a time and
// in_tready stays low meanwhile.
// Reset: entries_in_use returns to 4; the table keeps its contents and must be
// loaded before use. A stalled receiver holds the result word in the output
// register; a finished query then waits until that register is free.
`include "assert_macros.svh"

module rotary_axis_error_compensation #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, angle_a, angle_c, pos_x, pos_y, pos_z,
  // load_err_x, load_err_y, load_err_z, zero pad
  input  logic [207:0] in_tdata,
  // func
  input  logic         in_tuser,
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, err_x, err_y, err_z, zero pad
  output logic [151:0] out_tdata,
  // status
  output logic         out_tuser
);
  import raec_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW    = $clog2(TABLE_DEPTH + 1);
  localparam int EW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int IW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int DIF_W = POS_W + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_INTERP = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0]        state_r;
  logic [CFG_W-1:0]  entries_r;
  logic signed [ANGQ_W-1:0] qa_r;
  logic signed [ANGQ_W-1:0] qc_r;
  logic signed [POS_W-1:0]  px_r;
  logic signed [POS_W-1:0]  py_r;
  logic signed [POS_W-1:0]  pz_r;
  logic              out_valid_r;
  logic [151:0]      out_data_r;
  logic              out_user_r;

  logic              accept;
  logic [IDX_W-1:0]  in_idx;
  logic signed [ANG_W-1:0] in_a;
  logic signed [ANG_W-1:0] in_c;
  node_t             wr_node;
  logic              wr_en;
  logic [EW-1:0]     ent_ext;
  logic [NW-1:0]     scan_len;
  logic              scan_start;
  logic              scan_done;
  cand_t             cand;
  logic              interp_done;
  res_t              res;
  logic              out_load;
  logic signed [DIF_W-1:0] dx;
  logic signed [DIF_W-1:0] dy;
  logic signed [DIF_W-1:0] dz;
  logic signed [POS_W-1:0] ox;
  logic signed [POS_W-1:0] oy;
  logic signed [POS_W-1:0] oz;

  // input word fields
  assign in_idx     = in_tdata[9:0];
  assign in_a       = in_tdata[32:10];
  assign in_c       = in_tdata[55:33];
  assign wr_node.a  = in_a;
  assign wr_node.c  = in_c;
  assign wr_node.ex = in_tdata[160:140];
  assign wr_node.ey = in_tdata[181:161];
  assign wr_node.ez = in_tdata[202:182];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign wr_en      = accept && !in_tuser && (IW'(in_idx) < IW'(TABLE_DEPTH));
  assign scan_start = accept && in_tuser;

  // scan length capped at the table depth
  assign ent_ext  = EW'(entries_r);
  assign scan_len = (ent_ext < EW'(TABLE_DEPTH)) ? NW'(ent_ext) : NW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_W'(4);
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // query operands, C wrapped into the positive turn
  always_ff @(posedge clk) begin
    if (scan_start) begin
      qa_r <= ANGQ_W'(in_a);
      qc_r <= (in_c < 0) ? ANGQ_W'(in_c) + ANGQ_W'(C_WRAP) : ANGQ_W'(in_c);
      px_r <= in_tdata[83:56];
      py_r <= in_tdata[111:84];
      pz_r <= in_tdata[139:112];
    end
  end

  raec_scan #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .NW    (NW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (AW'(in_idx)),
    .wr_data  (wr_node),
    .start    (scan_start),
    .q_a      (qa_r),
    .q_c      (qc_r),
    .scan_len (scan_len),
    .done     (scan_done),
    .cand     (cand)
  );

  raec_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_done),
    .q_a   (qa_r),
    .q_c   (qc_r),
    .cand  (cand),
    .done  (interp_done),
    .res   (res)
  );

  // item sequencing
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE:   if (scan_start) state_r <= ST_SCAN;
        ST_SCAN:   if (scan_done) state_r <= ST_INTERP;
        ST_INTERP: if (interp_done) state_r <= ST_HOLD;
        ST_HOLD:   if (out_load) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  // corrected position, saturated
  assign dx = DIF_W'(px_r) - DIF_W'(res.ex);
  assign dy = DIF_W'(py_r) - DIF_W'(res.ey);
  assign dz = DIF_W'(pz_r) - DIF_W'(res.ez);
  assign ox = POS_W'(clamp64(64'(dx), 64'(OUT_MAX)));
  assign oy = POS_W'(clamp64(64'(dy), 64'(OUT_MAX)));
  assign oz = POS_W'(clamp64(64'(dz), 64'(OUT_MAX)));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'b0, res.ez, res.ey, res.ex, oz, oy, ox};
      out_user_r <= res.degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a degenerate span always carries zero error
  `ASSERT_IMPL(a_degen_zero, out_tvalid && out_tuser, out_tdata[146:84] == '0)
  // the table scan only finishes while a query is in the scan phase
  `ASSERT_IMPL(a_scan_done_phase, scan_done, state_r == ST_SCAN)
  // an accepted query closes the input until its result is delivered
  `ASSERT_NEXT(a_query_busy, scan_start, !in_tready)
  // a waiting result is never overwritten by the next one
  `ASSERT_NEXT(a_hold_waits, state_r == ST_HOLD && out_valid_r && !out_tready,
               state_r == ST_HOLD)

endmodule
